FILE: hw/rtl/acd_pkg.sv
// Shared types, constants and codes for the area container cell deframer.
`timescale 1ns / 1ps
`default_nettype none
package acd_pkg;

    localparam int GRID_CELLS_DEFAULT = 256;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [31:0] SIG_A           = 32'h6172_6561;
    localparam logic [31:0] SIG_B           = 32'h4152_4541;
    localparam logic [31:0] CONTAINER_MAGIC = 32'h4348_4E4B;

    typedef enum logic [3:0] {
        PH_SIG      = 4'd0,
        PH_VER      = 4'd1,
        PH_RECMAG   = 4'd2,
        PH_RECSIZE  = 4'd3,
        PH_RECSKIP  = 4'd4,
        PH_CELLHDR  = 4'd5,
        PH_CELLPAY  = 4'd6,
        PH_CELLSKIP = 4'd7,
        PH_HALT     = 4'd8
    } phase_t;

    typedef enum logic [3:0] {
        KIND_PAYLOAD    = 4'd0,
        KIND_CELL_HDR   = 4'd1,
        KIND_SHORT_CELL = 4'd2,
        KIND_BAD_SIG    = 4'd3,
        KIND_TOO_SHORT  = 4'd4,
        KIND_TRUNC_REC  = 4'd5,
        KIND_IDX_OVF    = 4'd6,
        KIND_TRUNC_CELL = 4'd7,
        KIND_DONE       = 4'd8
    } kind_t;

    // One input word after classification by the front end.
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic        short_file;  // file_length below 8
        logic        avail_lt8;   // fewer than 8 bytes left at this byte
        logic [31:0] rest;        // bytes left after this one
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload;
        logic [7:0]  cell_number;
        logic [3:0]  cell_column;
        logic [3:0]  cell_row;
        logic [23:0] cell_bytes;
        logic        first_of_cell;
        logic        last_of_cell;
        logic [15:0] record_ordinal;
        logic        stream_end;
    } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/area_container_cell_deframer.sv
// Top level of the area container cell deframer.
//
// Usage: file bytes enter through a queue-style port: a word is taken at a clock
// edge where push is high and full is low; final_byte marks the last byte of a file.
// Results leave through a second queue port: while empty is low the oldest result
// sits on the result ports and pop takes it. file_length is written over its own
// valid/ready channel (ready is always high); the user must write it only while
// the block is idle, as the block does not enforce this. Each byte gives zero or
// one result, registered in the result queue after the byte leaves the input queue.
// Throughput is one byte per cycle while the result queue has room, set by the
// parser's one-byte-per-cycle state update; four-word queues sit before and after it.
// When the receiver stops popping, the result queue fills, the parser stalls, the
// input queue fills and full rises; nothing is lost or repeated.
// Reset clears both queues, the parse state and file_length to zero; the block
// accepts bytes in the first cycle after reset. After a final byte the parse state
// returns to its reset value, so the next byte starts a new file.
`timescale 1ns / 1ps
`default_nettype none
module area_container_cell_deframer
    import acd_pkg::*;
#(
    parameter int GRID_CELLS = GRID_CELLS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] file_length,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       kind,
    output logic [7:0]       payload,
    output logic [7:0]       cell_number,
    output logic [3:0]       cell_column,
    output logic [3:0]       cell_row,
    output logic [23:0]      cell_bytes,
    output logic             first_of_cell,
    output logic             last_of_cell,
    output logic [15:0]      record_ordinal,
    output logic             stream_end
);
    localparam int IN_W  = $bits(in_item_t);
    localparam int RES_W = $bits(result_t);

    in_item_t   front_item;
    in_item_t   mid_item;
    logic [IN_W-1:0]  mid_rd_data;
    logic             mid_empty;
    logic             in_accept;
    logic             consume;
    logic             res_full;
    logic             res_valid;
    result_t          res;
    result_t          out_res;
    logic [RES_W-1:0] out_rd_data;

    assign cfg_ready = 1'b1;
    assign in_accept = push && !full;
    assign consume   = !mid_empty && !res_full;
    assign mid_item  = in_item_t'(mid_rd_data);
    assign out_res   = result_t'(out_rd_data);

    acd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (file_length),
        .accept     (in_accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .item       (front_item)
    );

    acd_fifo #(
        .WIDTH (IN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_item),
        .rd_en   (consume),
        .rd_data (mid_rd_data),
        .full    (full),
        .empty   (mid_empty)
    );

    acd_parser #(
        .GRID_CELLS (GRID_CELLS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .consume   (consume),
        .item      (mid_item),
        .res_valid (res_valid),
        .res       (res)
    );

    acd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .full    (res_full),
        .empty   (empty)
    );

    assign kind           = out_res.kind;
    assign payload        = out_res.payload;
    assign cell_number    = out_res.cell_number;
    assign cell_column    = out_res.cell_column;
    assign cell_row       = out_res.cell_row;
    assign cell_bytes     = out_res.cell_bytes;
    assign first_of_cell  = out_res.first_of_cell;
    assign last_of_cell   = out_res.last_of_cell;
    assign record_ordinal = out_res.record_ordinal;
    assign stream_end     = out_res.stream_end;

endmodule
`default_nettype wire

FILE: hw/rtl/acd_fifo.sv
// Small first-in first-out queue of fixed-width words.
`timescale 1ns / 1ps
`default_nettype none
module acd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/acd_front.sv
// Front end: holds file_length, tracks the byte position and classifies each byte.
`timescale 1ns / 1ps
`default_nettype none
module acd_front
    import acd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [31:0] cfg_data,
    input  wire logic        accept,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output in_item_t         item
);
    logic [31:0] file_length_reg;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] avail;

    assign avail = (file_length_reg > pos_reg) ? (file_length_reg - pos_reg) : '0;

    always_comb
    begin
        item.data       = data_byte;
        item.fin        = final_byte;
        item.short_file = (file_length_reg < 32'd8);
        item.avail_lt8  = (avail < 32'd8);
        item.rest       = (avail != '0) ? (avail - 32'd1) : '0;

        pos_next = pos_reg;
        if (accept)
        begin
            // The position restarts with each new file and saturates at its all-ones maximum.
            if (final_byte)
            begin
                pos_next = '0;
            end
            else if (pos_reg != '1)
            begin
                pos_next = pos_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
            pos_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                file_length_reg <= cfg_data;
            end
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/acd_parser.sv
// Back end: walks signature, records and cell headers and builds at most one result per byte.
`timescale 1ns / 1ps
`default_nettype none
module acd_parser
    import acd_pkg::*;
#(
    parameter int GRID_CELLS = GRID_CELLS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     consume,
    input  wire in_item_t item,
    output logic          res_valid,
    output result_t       res
);
    localparam int IDX_W = $clog2(GRID_CELLS + 256);

    phase_t      phase_reg, phase_next;
    logic [31:0] ws_reg, ws_next;
    logic [1:0]  biw_reg, biw_next;
    logic        is_cont_reg, is_cont_next;
    logic [31:0] rec_rem_reg, rec_rem_next;
    logic [23:0] cell_rem_reg, cell_rem_next;
    logic [IDX_W-1:0] next_idx_reg, next_idx_next;
    logic [7:0]  cur_num_reg, cur_num_next;
    logic [23:0] cur_size_reg, cur_size_next;
    logic [15:0] count_reg, count_next;

    logic [31:0] ws_shift;
    logic        word_done;
    logic [1:0]  biw_take;
    logic [31:0] rec_dec;
    logic [23:0] cell_dec;
    logic [IDX_W-1:0] idx_sum;
    logic [23:0] hdr_size;
    logic        have;

    assign ws_shift  = {item.data, ws_reg[31:8]};
    assign word_done = (biw_reg == 2'd3);
    assign biw_take  = word_done ? 2'd0 : biw_reg + 2'd1;
    assign rec_dec   = rec_rem_reg - {31'd0, (rec_rem_reg != '0)};
    assign cell_dec  = cell_rem_reg - {23'd0, (cell_rem_reg != '0)};
    assign idx_sum   = IDX_W'(ws_shift[31:24]) + next_idx_reg;
    assign hdr_size  = ws_shift[23:0];

    always_comb
    begin
        phase_next    = phase_reg;
        ws_next       = ws_reg;
        biw_next      = biw_reg;
        is_cont_next  = is_cont_reg;
        rec_rem_next  = rec_rem_reg;
        cell_rem_next = cell_rem_reg;
        next_idx_next = next_idx_reg;
        cur_num_next  = cur_num_reg;
        cur_size_next = cur_size_reg;
        count_next    = count_reg;
        have          = 1'b0;
        res           = '0;

        unique case (phase_reg)
            PH_SIG:
            begin
                if (biw_reg == 2'd0 && item.short_file)
                begin
                    have       = 1'b1;
                    res.kind   = KIND_TOO_SHORT;
                    phase_next = PH_HALT;
                end
                else
                begin
                    ws_next  = ws_shift;
                    biw_next = biw_take;
                    if (word_done)
                    begin
                        if (ws_shift != SIG_A && ws_shift != SIG_B)
                        begin
                            have       = 1'b1;
                            res.kind   = KIND_BAD_SIG;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            phase_next = PH_VER;
                        end
                    end
                end
            end
            PH_VER:
            begin
                ws_next  = ws_shift;
                biw_next = biw_take;
                if (word_done)
                begin
                    phase_next = PH_RECMAG;
                end
            end
            PH_RECMAG:
            begin
                if (biw_reg == 2'd0 && item.avail_lt8)
                begin
                    have       = 1'b1;
                    res.kind   = KIND_DONE;
                    phase_next = PH_HALT;
                end
                else
                begin
                    ws_next  = ws_shift;
                    biw_next = biw_take;
                    if (word_done)
                    begin
                        is_cont_next = (ws_shift == CONTAINER_MAGIC);
                        phase_next   = PH_RECSIZE;
                    end
                end
            end
            PH_RECSIZE:
            begin
                ws_next  = ws_shift;
                biw_next = biw_take;
                if (word_done)
                begin
                    if (ws_shift > item.rest)
                    begin
                        have       = 1'b1;
                        res.kind   = KIND_TRUNC_REC;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        rec_rem_next = ws_shift;
                        if (is_cont_reg)
                        begin
                            if (count_reg != '1)
                            begin
                                count_next = count_reg + 16'd1;
                            end
                            next_idx_next = '0;
                            phase_next    = PH_CELLHDR;
                        end
                        else
                        begin
                            phase_next = PH_RECSKIP;
                        end
                        if (ws_shift == '0)
                        begin
                            phase_next = PH_RECMAG;
                        end
                    end
                end
            end
            PH_RECSKIP:
            begin
                rec_rem_next = rec_dec;
                if (rec_dec == '0)
                begin
                    phase_next = PH_RECMAG;
                end
            end
            PH_CELLHDR:
            begin
                rec_rem_next = rec_dec;
                if (biw_reg == 2'd0 && rec_rem_reg < 32'd4)
                begin
                    // A container tail too short for a header is dropped silently.
                    phase_next = (rec_dec != '0) ? PH_RECSKIP : PH_RECMAG;
                end
                else
                begin
                    ws_next  = ws_shift;
                    biw_next = biw_take;
                    if (word_done)
                    begin
                        have            = 1'b1;
                        next_idx_next   = idx_sum + 1'b1;
                        cur_size_next   = hdr_size;
                        cur_num_next    = idx_sum[7:0];
                        res.cell_number = idx_sum[7:0];
                        res.cell_column = idx_sum[3:0];
                        res.cell_row    = idx_sum[7:4];
                        res.cell_bytes  = hdr_size;
                        if (idx_sum >= IDX_W'(GRID_CELLS))
                        begin
                            res.kind   = KIND_IDX_OVF;
                            phase_next = (rec_dec != '0) ? PH_RECSKIP : PH_RECMAG;
                        end
                        else if ({8'd0, hdr_size} > rec_dec)
                        begin
                            res.kind   = KIND_TRUNC_CELL;
                            phase_next = (rec_dec != '0) ? PH_RECSKIP : PH_RECMAG;
                        end
                        else if (hdr_size < 24'd4)
                        begin
                            res.kind      = KIND_SHORT_CELL;
                            cell_rem_next = hdr_size;
                            if (hdr_size == '0)
                            begin
                                phase_next = (rec_dec != '0) ? PH_CELLHDR : PH_RECMAG;
                            end
                            else
                            begin
                                phase_next = PH_CELLSKIP;
                            end
                        end
                        else
                        begin
                            res.kind      = KIND_CELL_HDR;
                            cell_rem_next = hdr_size;
                            phase_next    = PH_CELLPAY;
                        end
                    end
                end
            end
            PH_CELLPAY:
            begin
                have              = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload       = item.data;
                res.cell_number   = cur_num_reg;
                res.cell_column   = cur_num_reg[3:0];
                res.cell_row      = cur_num_reg[7:4];
                res.cell_bytes    = cur_size_reg;
                res.first_of_cell = (cell_rem_reg == cur_size_reg);
                res.last_of_cell  = (cell_rem_reg <= 24'd1);
                rec_rem_next      = rec_dec;
                cell_rem_next     = cell_dec;
                if (cell_dec == '0)
                begin
                    phase_next = (rec_dec != '0) ? PH_CELLHDR : PH_RECMAG;
                end
            end
            PH_CELLSKIP:
            begin
                rec_rem_next  = rec_dec;
                cell_rem_next = cell_dec;
                if (cell_dec == '0)
                begin
                    phase_next = (rec_dec != '0) ? PH_CELLHDR : PH_RECMAG;
                end
            end
            PH_HALT:
            begin
                phase_next = PH_HALT;
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase

        res.record_ordinal = count_next;

        // The last byte of a file always closes it, and the next byte starts afresh.
        if (item.fin)
        begin
            if (!have && phase_reg != PH_HALT)
            begin
                have               = 1'b1;
                res                = '0;
                res.kind           = KIND_DONE;
                res.record_ordinal = count_next;
            end
            res.stream_end = have;
            phase_next    = PH_SIG;
            ws_next       = '0;
            biw_next      = '0;
            is_cont_next  = 1'b0;
            rec_rem_next  = '0;
            cell_rem_next = '0;
            next_idx_next = '0;
            cur_num_next  = '0;
            cur_size_next = '0;
            count_next    = '0;
        end

        res_valid = consume && have;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIG;
            ws_reg       <= '0;
            biw_reg      <= '0;
            is_cont_reg  <= 1'b0;
            rec_rem_reg  <= '0;
            cell_rem_reg <= '0;
            next_idx_reg <= '0;
            cur_num_reg  <= '0;
            cur_size_reg <= '0;
            count_reg    <= '0;
        end
        else if (consume)
        begin
            phase_reg    <= phase_next;
            ws_reg       <= ws_next;
            biw_reg      <= biw_next;
            is_cont_reg  <= is_cont_next;
            rec_rem_reg  <= rec_rem_next;
            cell_rem_reg <= cell_rem_next;
            next_idx_reg <= next_idx_next;
            cur_num_reg  <= cur_num_next;
            cur_size_reg <= cur_size_next;
            count_reg    <= count_next;
        end
    end

endmodule
`default_nettype wire
